// ===== hw/rtl/lfu_cache_table_assert.svh =====
// Assertion macros used by the checker file lfuct_checker.sv.
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// Same-cycle implication, skipped while reset is low.
`define LFUCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, skipped while reset is low.
`define LFUCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lfuct_pkg.sv =====
`timescale 1ns / 1ps
package lfuct_pkg;

    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_UPDATE
    } t_state;

    // Broadcast control from the sequencer to every cell of the row.
    typedef struct packed {
        logic                  compare;    // latch key match
        logic                  update;     // apply the row shift this cycle
        logic                  touch;      // move the matched entry to its new place
        logic                  evict;      // drop the last valid entry
        logic [COUNT_BITS-1:0] new_count;  // use count of the entry being placed
    } t_cell_ctrl;

endpackage

// ===== hw/rtl/lfu_cache_table.sv =====
`timescale 1ns / 1ps
// Result strobe o_done is registered from the update state (order: compare, then update).
// Start is taken again in the update state, so a new item can enter before the last result
//   shows. The compare and update states hold the key compare and the row shift.
// Reset (i_rst_n low, synchronous): all entries invalid, occupancy zero, capacity 16.
// Results cannot be stalled by the receiver; each is shown for exactly one cycle.
module lfu_cache_table #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_func,
    input  logic [KEY_BITS-1:0]            i_key,
    input  logic [VALUE_BITS-1:0]          i_value,
    input  logic                           i_cfg_we,
    input  logic [lfuct_pkg::CAP_BITS-1:0] i_cfg_wdata,
    output logic                           o_done,
    output logic                           o_hit,
    output logic [VALUE_BITS-1:0]          o_read_value,
    output logic                           o_evicted,
    output logic [KEY_BITS-1:0]            o_evicted_key
);

    localparam int OccW = $clog2(ENTRIES + 1);
    localparam int CmpW = 9;  // holds counts up to 511

    // Sequencer: IDLE -> COMPARE -> UPDATE, back to COMPARE when a new start lands, else to IDLE.
    lfuct_pkg::t_state r_state;
    lfuct_pkg::t_state n_state;
    logic              compare_en;
    logic              update_en;
    logic              accept;

    // Configuration and occupancy.
    logic [lfuct_pkg::CAP_BITS-1:0] r_cap;
    logic [OccW-1:0]                r_occ;
    logic [OccW-1:0]                n_occ;

    // Operation held across the compare and update cycles.
    logic                             r_func;
    logic [KEY_BITS-1:0]              r_key;
    logic [VALUE_BITS-1:0]            r_value;
    logic                             r_hit;
    logic [VALUE_BITS-1:0]            r_hit_value;
    logic [lfuct_pkg::COUNT_BITS-1:0] r_bumped;

    // Result registers.
    logic                  r_done;
    logic                  r_res_hit;
    logic [VALUE_BITS-1:0] r_res_value;
    logic                  r_res_evicted;
    logic [KEY_BITS-1:0]   r_res_evicted_key;

    // Row wiring.
    lfuct_pkg::t_cell_ctrl            ctrl;
    logic [ENTRIES:0]                 seen_chain;
    logic [ENTRIES:0]                 tail_chain;
    logic [ENTRIES-1:0]               match_now;
    logic [ENTRIES-1:0]               cell_valid;
    logic [ENTRIES-1:0]               last_valid;
    logic [KEY_BITS-1:0]              cell_key   [ENTRIES];
    logic [VALUE_BITS-1:0]            cell_value [ENTRIES];
    logic [lfuct_pkg::COUNT_BITS-1:0] cell_count [ENTRIES];

    // Compare-cycle reductions (the match is one-hot: keys in the row are unique).
    logic                             hit_now;
    logic [VALUE_BITS-1:0]            hit_value_now;
    logic [lfuct_pkg::COUNT_BITS-1:0] hit_count_now;

    // Update-cycle decisions.
    logic [CmpW-1:0]       cap_eff;
    logic                  cap_zero;
    logic                  do_insert;
    logic                  do_evict;
    logic                  do_update;
    logic [VALUE_BITS-1:0] place_value;
    logic [KEY_BITS-1:0]   victim_key;

    assign accept = start && !busy;

    always_comb begin
        unique case (r_state)
            lfuct_pkg::ST_IDLE:    n_state = accept ? lfuct_pkg::ST_COMPARE : lfuct_pkg::ST_IDLE;
            lfuct_pkg::ST_COMPARE: n_state = lfuct_pkg::ST_UPDATE;
            lfuct_pkg::ST_UPDATE:  n_state = accept ? lfuct_pkg::ST_COMPARE : lfuct_pkg::ST_IDLE;
            default:               n_state = lfuct_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            lfuct_pkg::ST_COMPARE: begin
                busy       = 1'b1;
                compare_en = 1'b1;
                update_en  = 1'b0;
            end
            lfuct_pkg::ST_UPDATE: begin
                busy       = 1'b0;
                compare_en = 1'b0;
                update_en  = 1'b1;
            end
            default: begin
                busy       = 1'b0;
                compare_en = 1'b0;
                update_en  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfuct_pkg::ST_IDLE;
            r_cap   <= lfuct_pkg::CAP_RESET;
            r_occ   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_done  <= update_en;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // Capture the operation on the start transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    // Compare cycle: fold the matching cell's value and count, pre-bump the count.
    always_comb begin
        hit_value_now = '0;
        hit_count_now = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (match_now[k]) begin
                hit_value_now = hit_value_now | cell_value[k];
                hit_count_now = hit_count_now | cell_count[k];
            end
        end
        hit_now = |match_now;
    end

    always_ff @(posedge i_clk) begin
        if (compare_en) begin
            r_hit       <= hit_now;
            r_hit_value <= hit_value_now;
            r_bumped    <= (hit_count_now == lfuct_pkg::COUNT_MAX) ? lfuct_pkg::COUNT_MAX
                         : hit_count_now + lfuct_pkg::COUNT_BITS'(1);
        end
    end

    // Update cycle: touch on a hit, insert on a put miss, evicting the row tail when full; no change at capacity zero.
    always_comb begin
        cap_eff   = (CmpW'(r_cap) > CmpW'(ENTRIES)) ? CmpW'(ENTRIES) : CmpW'(r_cap);
        cap_zero  = (r_cap == '0);
        do_insert = (r_func == lfuct_pkg::FUNC_PUT) && !r_hit;
        do_evict  = do_insert && (CmpW'(r_occ) >= cap_eff);
        do_update = update_en && !cap_zero && (r_hit || do_insert);

        ctrl.compare   = compare_en;
        ctrl.update    = do_update;
        ctrl.touch     = r_hit;
        ctrl.evict     = do_evict;
        ctrl.new_count = r_hit ? r_bumped : lfuct_pkg::COUNT_BITS'(1);

        place_value = (r_func == lfuct_pkg::FUNC_PUT) ? r_value : r_hit_value;

        n_occ = r_occ;
        if (do_update && do_insert && !do_evict) begin
            n_occ = r_occ + OccW'(1);
        end
    end

    // Victim sits in the last valid cell.
    always_comb begin
        victim_key = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (last_valid[k]) begin
                victim_key = victim_key | cell_key[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (update_en) begin
            r_res_hit         <= !cap_zero && r_hit;
            r_res_value       <= (!cap_zero && r_hit && (r_func == lfuct_pkg::FUNC_GET))
                               ? r_hit_value : '0;
            r_res_evicted     <= do_update && do_evict;
            r_res_evicted_key <= (do_update && do_evict) ? victim_key : '0;
        end
    end

    assign seen_chain[0]       = 1'b0;
    assign tail_chain[ENTRIES] = 1'b0;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        logic                             left_valid;
        logic [KEY_BITS-1:0]              left_key;
        logic [VALUE_BITS-1:0]            left_value;
        logic [lfuct_pkg::COUNT_BITS-1:0] left_count;
        logic                             right_valid;

        if (k == 0) begin : g_head
            // Head cell never shifts in; it counts as having a full neighbor.
            assign left_valid = 1'b1;
            assign left_key   = '0;
            assign left_value = '0;
            assign left_count = '0;
        end else begin : g_body
            assign left_valid = cell_valid[k-1];
            assign left_key   = cell_key[k-1];
            assign left_value = cell_value[k-1];
            assign left_count = cell_count[k-1];
        end

        if (k == ENTRIES - 1) begin : g_last
            assign right_valid = 1'b0;
        end else begin : g_inner
            assign right_valid = cell_valid[k+1];
        end

        assign last_valid[k] = cell_valid[k] && !right_valid;

        lfuct_cell #(
            .KEY_BITS  (KEY_BITS),
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_key        (r_key),
            .i_value      (place_value),
            .i_left_valid (left_valid),
            .i_left_key   (left_key),
            .i_left_value (left_value),
            .i_left_count (left_count),
            .i_right_valid(right_valid),
            .i_seen       (seen_chain[k]),
            .i_tail       (tail_chain[k+1]),
            .o_seen       (seen_chain[k+1]),
            .o_tail       (tail_chain[k]),
            .o_match_now  (match_now[k]),
            .o_valid      (cell_valid[k]),
            .o_key        (cell_key[k]),
            .o_value      (cell_value[k]),
            .o_count      (cell_count[k])
        );
    end

    assign o_done        = r_done;
    assign o_hit         = r_res_hit;
    assign o_read_value  = r_res_value;
    assign o_evicted     = r_res_evicted;
    assign o_evicted_key = r_res_evicted_key;

endmodule

// ===== hw/rtl/lfuct_cell.sv =====
`timescale 1ns / 1ps
// One entry of the sorted row: use count descending, newer first among equals.
module lfuct_cell #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lfuct_pkg::t_cell_ctrl            i_ctrl,
    input  logic [KEY_BITS-1:0]              i_key,
    input  logic [VALUE_BITS-1:0]            i_value,
    input  logic                             i_left_valid,
    input  logic [KEY_BITS-1:0]              i_left_key,
    input  logic [VALUE_BITS-1:0]            i_left_value,
    input  logic [lfuct_pkg::COUNT_BITS-1:0] i_left_count,
    input  logic                             i_right_valid,
    input  logic                             i_seen,
    input  logic                             i_tail,
    output logic                             o_seen,
    output logic                             o_tail,
    output logic                             o_match_now,
    output logic                             o_valid,
    output logic [KEY_BITS-1:0]              o_key,
    output logic [VALUE_BITS-1:0]            o_value,
    output logic [lfuct_pkg::COUNT_BITS-1:0] o_count
);

    logic                             r_valid;
    logic                             r_match;
    logic [KEY_BITS-1:0]              r_key;
    logic [VALUE_BITS-1:0]            r_value;
    logic [lfuct_pkg::COUNT_BITS-1:0] r_count;

    logic remove_here;
    logic insert_here;
    logic take_new;
    logic take_left;

    always_comb begin
        o_match_now = r_valid && (r_key == i_key);
        // Place the entry leaves (or the free cell that fills).
        if (i_ctrl.touch) begin
            remove_here = r_match;
        end else if (i_ctrl.evict) begin
            remove_here = r_valid && !i_right_valid;
        end else begin
            remove_here = !r_valid && i_left_valid;
        end
        insert_here = (r_valid && (r_count <= i_ctrl.new_count)) || remove_here;
        o_seen      = i_seen || insert_here;
        o_tail      = i_tail || remove_here;
        take_new    = i_ctrl.update && insert_here && !i_seen;
        take_left   = i_ctrl.update && i_seen && o_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctrl.compare) begin
                r_match <= o_match_now;
            end
            if (take_new) begin
                r_valid <= 1'b1;
            end else if (take_left) begin
                r_valid <= i_left_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_new) begin
            r_key   <= i_key;
            r_value <= i_value;
            r_count <= i_ctrl.new_count;
        end else if (take_left) begin
            r_key   <= i_left_key;
            r_value <= i_left_value;
            r_count <= i_left_count;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_count = r_count;

endmodule

// ===== hw/rtl/lfuct_checker.sv =====
`timescale 1ns / 1ps
`include "lfu_cache_table_assert.svh"
module lfuct_checker #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_done,
    input logic                  o_hit,
    input logic [VALUE_BITS-1:0] o_read_value,
    input logic                  o_evicted,
    input logic [KEY_BITS-1:0]   o_evicted_key
);

    logic evict_shown;

    assign evict_shown = o_done && (o_evicted || (o_evicted_key != '0));

    // Every transfer is followed by exactly one compare cycle.
    `LFUCT_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy, "no busy")
    `LFUCT_ASSERT_NEXT(a_busy_one_cycle, i_clk, i_rst_n, busy, !busy, "busy held too long")
    // A result only follows a start transfer, through the compare and update states.
    `LFUCT_ASSERT_NOW(a_done_start, i_clk, i_rst_n, o_done, $past(start && !busy, 3), "stray done")
    // An eviction only happens on a miss; a miss reads zero and no key is reported without eviction.
    `LFUCT_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_done && !o_hit, o_read_value == '0, "miss data")
    `LFUCT_ASSERT_NOW(a_evict_miss, i_clk, i_rst_n, evict_shown, o_evicted && !o_hit, "bad eviction")

endmodule

bind lfu_cache_table lfuct_checker #(
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
) u_lfuct_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_hit        (o_hit),
    .o_read_value (o_read_value),
    .o_evicted    (o_evicted),
    .o_evicted_key(o_evicted_key)
);
